>>> hdl/periodic_event_scheduler_top_assert.svh
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by the checker file.
`ifndef PERIODIC_EVENT_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_EVENT_SCHEDULER_TOP_ASSERT_SVH
`define PES_ASSERT_IMPL(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");
`define PES_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");
`endif

>>> hdl/pes_pkg.sv
// Package of the periodic event scheduler: codes, constants and command and status types.
// Depends on nothing.
package pes_pkg;
   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_SET_PERIOD = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_FIRED = 3'd4;
   localparam logic [2:0] ST_SUMMARY = 3'd5;
   localparam logic [30:0] PM_MULT = 31'd16807;
   localparam logic [30:0] PM_MOD = 31'h7FFFFFFF;

   typedef struct packed {
      logic load;       // capture request item
      logic scan_rst;   // clear scan index and results
      logic step_find;  // compare one entry for key match
      logic seed_step;  // advance the seed
      logic rnd_start;  // start period*seed/MOD
      logic write_new;  // write entry at count
      logic write_idx;  // write entry at match index
      logic tick_init;  // initialize wake limit
      logic tick_read;  // read entry at index
      logic mod_start;  // start remainder
      logic tick_upd;   // update due and wake limit for current entry
      logic idx_inc;    // next entry
      logic wake_commit;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic idx_end;    // index reached count
      logic full;
      logic div_busy;
      logic active;     // period nonzero
      logic due;        // due <= now
      logic wake_hit;   // now >= next_wake
   } sts_type;
endpackage

>>> hdl/pes_datapath.sv
// Datapath: entry memories, Park-Miller seed, serial divider and wake tracking.
// Depends on pes_pkg.
module pes_datapath #(
   parameter int DEPTH = 16,
   parameter int IW = 4,
   parameter int CW = 5
) (
   input  logic clock,
   input  logic reset,
   input  pes_pkg::cmd_type cmd,
   output pes_pkg::sts_type sts,
   input  logic [106:0] req_item,
   input  logic [15:0] max_wake,
   output logic [56:0] key_out,
   output logic [31:0] wake_out
);
   logic [56:0] key_mem [DEPTH];
   logic [15:0] per_mem [DEPTH];
   logic [31:0] due_mem [DEPTH];
   logic [56:0] key_ff;
   logic [15:0] per_ff;
   logic [31:0] now_ff, due_ff, wake_ff, limit_ff, newdue_ff;
   logic [56:0] rkey_ff;
   logic [15:0] rper_ff;
   logic [31:0] rdue_ff;
   logic [CW-1:0] cnt_ff, idx_ff;
   logic [IW-1:0] hit_ff;
   logic found_ff;
   logic [30:0] seed_ff, seed_in;
   logic [46:0] lo, hi;
   logic [31:0] s1;
   // restoring divider for the tick remainder: dividend / divisor
   logic [47:0] dvd_ff;
   logic [31:0] dvs_ff;
   logic [31:0] rem_ff, rem_in;
   logic [47:0] quo_ff;
   logic [5:0] dcnt_ff;
   logic [32:0] trial;
   logic [15:0] rnd_per_ff;
   logic [46:0] prod;
   logic [31:0] rnd_sum;
   logic [15:0] rnd_q;

   function automatic logic [46:0] PM_MULT_EXT(input logic [15:0] v);
      return 47'(v) * 47'(pes_pkg::PM_MULT);
   endfunction

   assign hi = PM_MULT_EXT(16'(seed_ff[30:16]));
   assign lo = PM_MULT_EXT(seed_ff[15:0]);
   always_comb begin
      logic [31:0] l;
      l = lo[31:0] + {1'b0, hi[14:0], 16'd0} + 32'(hi[31:15]);
      if (l > {1'b0, pes_pkg::PM_MOD}) begin
         l = l - {1'b0, pes_pkg::PM_MOD};
      end
      s1 = l;
      seed_in = s1[30:0];
   end
   assign prod = 47'(rnd_per_ff) * 47'(seed_ff);
   // Division by 2^31 - 1: the high part plus one when the folded low part reaches the modulus.
   assign rnd_sum = {1'b0, prod[30:0]} + 32'(prod[46:31]);
   assign rnd_q = prod[46:31] + 16'(rnd_sum >= {1'b0, pes_pkg::PM_MOD});
   assign trial = {rem_ff, dvd_ff[47]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         seed_ff <= 31'd1;
         wake_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.seed_step) seed_ff <= seed_in;
         if (cmd.write_new) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.wake_commit) wake_ff <= limit_ff;
         if (cmd.rnd_start) begin
            quo_ff <= 48'(rnd_q);
         end else if (cmd.mod_start) begin
            dvd_ff <= {now_ff - rdue_ff, 16'd0};
            dvs_ff <= 32'(rper_ff);
            rem_ff <= '0;
            dcnt_ff <= 6'd32;
         end else if (dcnt_ff != 0) begin
            dcnt_ff <= dcnt_ff - 1'b1;
            dvd_ff <= {dvd_ff[46:0], 1'b0};
            if (!trial[32]) begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[30:0], dvd_ff[47]};
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_item[58:2];
         per_ff <= req_item[74:59];
         now_ff <= req_item[106:75];
         rnd_per_ff <= req_item[74:59];
      end
      if (cmd.scan_rst) begin
         idx_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.step_find) begin
         if (!found_ff && idx_ff != cnt_ff && key_mem[idx_ff[IW-1:0]] == key_ff) begin
            found_ff <= 1'b1;
            hit_ff <= idx_ff[IW-1:0];
         end
         if (idx_ff != cnt_ff) idx_ff <= idx_ff + 1'b1;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.write_new) begin
         key_mem[cnt_ff[IW-1:0]] <= key_ff;
         per_mem[cnt_ff[IW-1:0]] <= per_ff;
         due_mem[cnt_ff[IW-1:0]] <= quo_ff[31:0];
      end
      if (cmd.write_idx) begin
         per_mem[hit_ff] <= per_ff;
         due_mem[hit_ff] <= quo_ff[31:0];
      end
      if (cmd.tick_read) begin
         rkey_ff <= key_mem[idx_ff[IW-1:0]];
         rper_ff <= per_mem[idx_ff[IW-1:0]];
         rdue_ff <= due_mem[idx_ff[IW-1:0]];
      end
      if (cmd.tick_init) limit_ff <= now_ff + 32'(max_wake);
      if (cmd.tick_upd) begin
         logic [31:0] nd;
         nd = (rdue_ff <= now_ff) ? now_ff + 32'(rper_ff) - rem_ff : rdue_ff;
         due_mem[idx_ff[IW-1:0]] <= nd;
         if (nd < limit_ff) limit_ff <= nd;
      end
   end

   assign sts.found = found_ff;
   assign sts.idx_end = (idx_ff == cnt_ff);
   assign sts.full = (cnt_ff == CW'(DEPTH));
   assign sts.div_busy = (dcnt_ff != 0);
   assign sts.active = (rper_ff != 0);
   assign sts.due = (rdue_ff <= now_ff);
   assign sts.wake_hit = (now_ff >= wake_ff);
   assign key_out = rkey_ff;
   assign wake_out = wake_ff;
endmodule

>>> hdl/pes_controller.sv
// Controller state machine of the scheduler; drives the datapath and output register.
// Depends on pes_pkg.
module pes_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [1:0] op,
   input  pes_pkg::sts_type sts,
   output pes_pkg::cmd_type cmd,
   output logic emit,
   output logic [2:0] emit_status,
   output logic emit_last,
   output logic emit_key,
   input  logic out_free
);
   localparam logic [3:0] S_IDLE = 4'd0, S_FIND = 4'd1, S_DECIDE = 4'd2, S_DIV = 4'd3,
      S_WRITE = 4'd4, S_TCHK = 4'd5, S_TREAD = 4'd6, S_TEVAL = 4'd7, S_TMOD = 4'd8,
      S_TFIRE = 4'd9, S_TSUM = 4'd10, S_RESP = 4'd11, S_WAIT1 = 4'd12;
   logic [3:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [2:0] rs_ff, rs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= '0;
         rs_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         rs_ff <= rs_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      rs_in = rs_ff;
      cmd = '0;
      req_tready = 1'b0;
      emit = 1'b0;
      emit_status = pes_pkg::ST_OK;
      emit_last = 1'b1;
      emit_key = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cmd.scan_rst = 1'b1;
               op_in = op;
               if (op == pes_pkg::OP_TICK) state_in = S_TCHK;
               else if (op == pes_pkg::OP_RESERVED) state_in = S_IDLE;
               else state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.step_find = 1'b1;
            if (sts.idx_end || sts.found) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (op_ff == pes_pkg::OP_REGISTER && sts.found) begin
               rs_in = pes_pkg::ST_DUP; state_in = S_RESP;
            end else if (op_ff == pes_pkg::OP_REGISTER && sts.full) begin
               rs_in = pes_pkg::ST_FULL; state_in = S_RESP;
            end else if (op_ff == pes_pkg::OP_SET_PERIOD && !sts.found) begin
               rs_in = pes_pkg::ST_NOTFOUND; state_in = S_RESP;
            end else begin
               cmd.seed_step = 1'b1; state_in = S_WAIT1;
            end
         end
         S_WAIT1: begin
            cmd.rnd_start = 1'b1; state_in = S_DIV;
         end
         S_DIV: if (!sts.div_busy) state_in = S_WRITE;
         S_WRITE: begin
            if (op_ff == pes_pkg::OP_REGISTER) cmd.write_new = 1'b1;
            else cmd.write_idx = 1'b1;
            rs_in = pes_pkg::ST_OK; state_in = S_RESP;
         end
         S_RESP: if (out_free) begin
            emit = 1'b1; emit_status = rs_ff; state_in = S_IDLE;
         end
         S_TCHK: begin
            cmd.tick_init = 1'b1;
            state_in = sts.wake_hit ? S_TREAD : S_TSUM;
         end
         S_TREAD: begin
            if (sts.idx_end) begin
               cmd.wake_commit = 1'b1; state_in = S_TSUM;
            end else begin
               cmd.tick_read = 1'b1; state_in = S_TEVAL;
            end
         end
         S_TEVAL: begin
            if (!sts.active) begin
               cmd.idx_inc = 1'b1; state_in = S_TREAD;
            end else if (sts.due) begin
               cmd.mod_start = 1'b1; state_in = S_TMOD;
            end else begin
               cmd.tick_upd = 1'b1; cmd.idx_inc = 1'b1; state_in = S_TREAD;
            end
         end
         S_TMOD: if (!sts.div_busy) state_in = S_TFIRE;
         S_TFIRE: if (out_free) begin
            emit = 1'b1; emit_status = pes_pkg::ST_FIRED; emit_last = 1'b0;
            emit_key = 1'b1;
            cmd.tick_upd = 1'b1; cmd.idx_inc = 1'b1; state_in = S_TREAD;
         end
         S_TSUM: if (out_free) begin
            emit = 1'b1; emit_status = pes_pkg::ST_SUMMARY; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> hdl/periodic_event_scheduler_top.sv
// Usage: a table of periodic entries driven by register, set-period and tick transactions.
// Request tdata carries operation, key, period and current time; a register or set-period
// request yields one response, a tick one fired response per due entry and a summary marked
// by tlast, and a reserved request none. Register and set-period search the table one entry
// per cycle and then advance the seed and draw the random phase. A tick that scans reads
// each entry in turn, and each due entry adds a 32-step remainder in the serial divider.
// The remainder step bounds rate.
// A single output register holds each response; while rsp_tready is low the controller
// waits. A new request may be taken while the final response of the previous one waits.
// Reset clears the entry count, sets the seed to one, the wake time to zero and
// max_wake to 1000. Entry memories are not cleared; only entries below the count are read.
// The csr write sets max_wake_ms; the user must see that it is made only while the block is
// idle, which the block does not enforce. Depends on pes_pkg, pes_controller and pes_datapath.
module periodic_event_scheduler_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // operation[1:0], object_id, instance_id, event_type, target_kind, target_id,
   // period_ms, now_ms, zero pad to 112 bits
   input  logic [111:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status[2:0], fired_object, fired_instance, fired_event, fired_kind,
   // fired_target, next_wake_ms, zero pad to 96 bits
   output logic [95:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [15:0] csr_wdata
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   pes_pkg::cmd_type cmd;
   pes_pkg::sts_type sts;
   logic emit, emit_last, emit_key;
   logic [2:0] emit_status;
   logic [56:0] key;
   logic [31:0] wake;
   logic [15:0] max_wake_ff;
   logic vld_ff, last_ff;
   logic [95:0] data_ff;
   logic out_free;
   // The packed key order matches the tdata order starting at bit 2.
   logic [56:0] key_fields;

   assign key_fields = {key[15:0], key[16], key[24:17], key[40:25], key[56:41]};
   assign out_free = !vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wake_ff <= 16'd1000;
         vld_ff <= 1'b0;
      end else begin
         if (csr_we) max_wake_ff <= csr_wdata;
         if (emit) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
      if (emit) begin
         last_ff <= emit_last;
         data_ff <= {4'd0,
            (emit_status == pes_pkg::ST_SUMMARY) ? wake : 32'd0,
            emit_key ? key_fields : 57'd0, emit_status};
      end
   end

   pes_controller u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .op(req_tdata[1:0]), .sts(sts), .cmd(cmd), .emit(emit),
      .emit_status(emit_status), .emit_last(emit_last), .emit_key(emit_key),
      .out_free(out_free)
   );

   pes_datapath #(.DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_item({req_tdata[106:75], req_tdata[74:59],
         req_tdata[17:2], req_tdata[33:18], req_tdata[41:34], req_tdata[42],
         req_tdata[58:43], req_tdata[1:0]}),
      .max_wake(max_wake_ff), .key_out(key), .wake_out(wake)
   );

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;
endmodule

>>> hdl/pes_checker.sv
// Port-level checker of the scheduler, bound to the top level.
// Depends on pes_pkg and periodic_event_scheduler_top_assert.svh.
`include "periodic_event_scheduler_top_assert.svh"
module pes_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic [95:0] rsp_tdata
);
   `PES_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `PES_ASSERT_IMPL(a_last, rsp_tvalid, rsp_tlast == (rsp_tdata[2:0] != pes_pkg::ST_FIRED))
   `PES_ASSERT_IMPL(a_busy, rsp_tvalid && !rsp_tlast, !req_tready)
   `PES_ASSERT_IMPL(a_code, rsp_tvalid, rsp_tdata[2:0] <= pes_pkg::ST_SUMMARY)
endmodule

bind periodic_event_scheduler_top pes_checker u_chk (.*);

>>> dv/testbench.sv
// Self-checking testbench of the periodic event scheduler: register, set-period, tick and
// reserved transactions with random handshake gaps, checked against a behavioral predictor.
// Depends on pes_pkg and periodic_event_scheduler_top.
module testbench;
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] obj;
      logic [15:0] inst;
      logic [7:0]  evt;
      logic        kind;
      logic [15:0] target;
      logic [31:0] wake;
      logic        last;
   } rsp_item_type;

   class schedule_scoreboard;
      logic [56:0] keys[16];
      logic [15:0] periods[16];
      logic [31:0] due_times[16];
      int unsigned count;
      logic [30:0] seed;
      logic [31:0] wake_time;
      logic [15:0] max_wake;
      rsp_item_type pending[$];
      int          errors;

      function new();
         count = 0;
         seed = 1;
         wake_time = 0;
         max_wake = 1000;
         errors = 0;
      endfunction

      function logic [31:0] draw_phase(logic [15:0] p);
         logic [63:0] prod;
         prod = 64'(seed) * 64'd16807;
         seed = 31'(prod % 64'h7FFFFFFF);
         return 32'((64'(p) * 64'(seed)) / 64'h7FFFFFFF);
      endfunction

      function void push(logic [2:0] st, logic [56:0] k, logic [31:0] w, logic l);
         rsp_item_type r;
         r.status = st;
         r.obj = k[56:41];
         r.inst = k[40:25];
         r.evt = k[24:17];
         r.kind = k[16];
         r.target = k[15:0];
         r.wake = w;
         r.last = l;
         pending.push_back(r);
      endfunction

      function int find(logic [56:0] k);
         for (int i = 0; i < count; i++) begin
            if (keys[i] == k) begin
               return i;
            end
         end
         return -1;
      endfunction

      function void note_request(logic [1:0] op, logic [56:0] k, logic [15:0] p,
                                 logic [31:0] now);
         int idx;
         logic [31:0] lim;
         logic [31:0] off;
         idx = find(k);
         if (op == pes_pkg::OP_REGISTER) begin
            if (idx >= 0) begin
               push(pes_pkg::ST_DUP, 0, 0, 1);
            end else if (count >= 16) begin
               push(pes_pkg::ST_FULL, 0, 0, 1);
            end else begin
               keys[count] = k;
               periods[count] = p;
               due_times[count] = draw_phase(p);
               count++;
               push(pes_pkg::ST_OK, 0, 0, 1);
            end
         end else if (op == pes_pkg::OP_SET_PERIOD) begin
            if (idx < 0) begin
               push(pes_pkg::ST_NOTFOUND, 0, 0, 1);
            end else begin
               periods[idx] = p;
               due_times[idx] = draw_phase(p);
               push(pes_pkg::ST_OK, 0, 0, 1);
            end
         end else if (op == pes_pkg::OP_TICK) begin
            if (now >= wake_time) begin
               lim = now + max_wake;
               for (int i = 0; i < count; i++) begin
                  if (periods[i] != 0) begin
                     if (due_times[i] <= now) begin
                        off = (now - due_times[i]) % periods[i];
                        due_times[i] = now + periods[i] - off;
                        push(pes_pkg::ST_FIRED, keys[i], 0, 0);
                     end
                     if (due_times[i] < lim) begin
                        lim = due_times[i];
                     end
                  end
               end
               wake_time = lim;
            end
            push(pes_pkg::ST_SUMMARY, 0, wake_time, 1);
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type exp;
         if (pending.size() == 0) begin
            $error("unexpected response status %0d", got.status);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            errors++;
         end
         if (got.obj !== exp.obj) begin
            $error("fired_object expected %0h actual %0h", exp.obj, got.obj);
            errors++;
         end
         if (got.inst !== exp.inst) begin
            $error("fired_instance expected %0h actual %0h", exp.inst, got.inst);
            errors++;
         end
         if (got.evt !== exp.evt) begin
            $error("fired_event expected %0h actual %0h", exp.evt, got.evt);
            errors++;
         end
         if (got.kind !== exp.kind) begin
            $error("fired_kind expected %0h actual %0h", exp.kind, got.kind);
            errors++;
         end
         if (got.target !== exp.target) begin
            $error("fired_target expected %0h actual %0h", exp.target, got.target);
            errors++;
         end
         if (got.wake !== exp.wake) begin
            $error("next_wake_ms expected %0h actual %0h", exp.wake, got.wake);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last expected %0d actual %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 0;
   logic [15:0] csr_wdata = '0;

   schedule_scoreboard board = new();
   bit steady;
   logic [56:0] key_pool[24];
   logic [31:0] clock_ms;

   periodic_event_scheduler_top DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response({rsp_tdata[2:0], rsp_tdata[18:3], rsp_tdata[34:19],
                               rsp_tdata[42:35], rsp_tdata[43], rsp_tdata[59:44],
                               rsp_tdata[91:60], rsp_tlast});
      end
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 13);
      end
   end

   task automatic send(logic [1:0] op, logic [56:0] k, logic [15:0] p, logic [31:0] now);
      while (!steady && $urandom_range(99) < 13) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, now, p, k[15:0], k[16], k[24:17], k[40:25], k[56:41], op};
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (op != pes_pkg::OP_RESERVED) begin
         board.note_request(op, k, p, now);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
   endtask

   task automatic write_max_wake(logic [15:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.max_wake = v;
   endtask

   function automatic logic [56:0] rand_key();
      return {16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 16'($urandom)};
   endfunction

   function automatic logic [15:0] rand_period();
      case ($urandom_range(4))
         0: return 16'($urandom_range(0, 3));
         1: return 16'hFFFF;
         default: return 16'($urandom_range(1, 200));
      endcase
   endfunction

   task automatic random_phase(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         steady = (i >= n / 3 && i < n / 2);
         pick = $urandom_range(99);
         if (pick < 15) begin
            send(pes_pkg::OP_REGISTER, $urandom_range(3) == 0 ? rand_key()
                 : key_pool[$urandom_range(23)], rand_period(), $urandom);
         end else if (pick < 30) begin
            send(pes_pkg::OP_SET_PERIOD, $urandom_range(4) == 0 ? rand_key()
                 : key_pool[$urandom_range(23)], rand_period(), $urandom);
         end else if (pick < 97) begin
            clock_ms = clock_ms + $urandom_range(0, 150);
            send(pes_pkg::OP_TICK, rand_key(), 16'($urandom), clock_ms);
         end else begin
            send(pes_pkg::OP_RESERVED, rand_key(), 16'($urandom), $urandom);
         end
      end
      steady = 0;
   endtask

   initial begin
      #20000000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      steady = 0;
      clock_ms = 0;
      for (int i = 0; i < 24; i++) begin
         key_pool[i] = rand_key();
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(pes_pkg::OP_TICK, '0, 0, 32'd0);
      send(pes_pkg::OP_SET_PERIOD, key_pool[0], 16'd5, 0);
      send(pes_pkg::OP_REGISTER, key_pool[0], 16'd0, 0);
      send(pes_pkg::OP_REGISTER, key_pool[0], 16'd7, 0);
      send(pes_pkg::OP_REGISTER, key_pool[1], 16'hFFFF, 0);
      send(pes_pkg::OP_SET_PERIOD, key_pool[0], 16'd1, 0);
      send(pes_pkg::OP_SET_PERIOD, key_pool[0], 16'd0, 0);
      send(pes_pkg::OP_SET_PERIOD, key_pool[0], 16'd3, 0);
      send(pes_pkg::OP_TICK, '0, 0, 32'd1);
      send(pes_pkg::OP_TICK, '0, 0, 32'd0);
      send(pes_pkg::OP_TICK, '0, 0, 32'd5000);
      send(pes_pkg::OP_RESERVED, '1, 16'hFFFF, 32'hFFFFFFFF);
      for (int i = 2; i < 17; i++) begin
         send(pes_pkg::OP_REGISTER, key_pool[i], 16'($urandom_range(1, 50)), 0);
      end
      send(pes_pkg::OP_TICK, '0, 0, 32'hFFFFFFFF);
      send(pes_pkg::OP_TICK, '0, 0, 32'hFFFFFFFF);
      write_max_wake(16'd1);
      clock_ms = 32'hFFFFFF00;
      random_phase(60);
      write_max_wake(16'hFFFF);
      clock_ms = 100;
      random_phase(60);
      write_max_wake(16'd0);
      random_phase(40);
      write_max_wake(16'd1000);
      random_phase(40);
      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

>>> periodic_event_scheduler_top.f
+incdir+hdl
hdl/pes_pkg.sv
hdl/pes_datapath.sv
hdl/pes_controller.sv
hdl/periodic_event_scheduler_top.sv
hdl/pes_checker.sv
dv/testbench.sv
